// ===== rtl/cursor_mask_overlay_defines.svh =====
// ----------------------------------------------------------------------------
// cursor_mask_overlay_defines
// assertion macros shared by the cursor overlay rtl
// ----------------------------------------------------------------------------
`ifndef CURSOR_MASK_OVERLAY_DEFINES_SVH
`define CURSOR_MASK_OVERLAY_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CMO_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define CMO_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/cmo_pkg.sv =====
// ----------------------------------------------------------------------------
// cmo_pkg
// types, constants and codes for the cursor overlay
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cmo_pkg;

	localparam int SHAPE_WORDS = 16384;
	localparam int SHAPE_AW    = $clog2(SHAPE_WORDS);
	localparam int COORD_BITS  = 13;
	localparam int BADDR_W     = 21;

	localparam logic [12:0] COORD_MASK = 13'((1 << COORD_BITS) - 1);

	localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
	localparam logic [31:0] ALPHA_MASK = 32'hFF00_0000;
	localparam logic [31:0] RGB_MASK   = 32'h00FF_FFFF;
	localparam logic [31:0] ZERO_WORD  = 32'h0000_0000;
	localparam logic [2:0]  MSB_BIT    = 3'd7;

	localparam logic [7:0] RST_WIDTH  = 8'd32;
	localparam logic [8:0] RST_HEIGHT = 9'd64;
	localparam logic [9:0] RST_PITCH  = 10'd4;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_PIXEL = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		MODE_OFF   = 2'd0,
		MODE_MONO  = 2'd1,
		MODE_COLOR = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		REG_CURSOR_X     = 3'd0,
		REG_CURSOR_Y     = 3'd1,
		REG_CURSOR_MODE  = 3'd2,
		REG_SHAPE_WIDTH  = 3'd3,
		REG_SHAPE_HEIGHT = 3'd4,
		REG_SHAPE_PITCH  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic        opcode;
		logic [13:0] shape_word_addr;
		logic [31:0] shape_word;
		logic [12:0] pixel_x;
		logic [12:0] pixel_y;
		logic [31:0] desktop_pixel;
	} item_t;

	typedef struct packed {
		logic [31:0] pixel_out;
		logic        in_cursor;
	} result_t;

	typedef struct packed {
		logic [13:0] cursor_x;
		logic [13:0] cursor_y;
		logic [1:0]  cursor_mode;
		logic [7:0]  shape_width;
		logic [8:0]  shape_height;
		logic [9:0]  shape_pitch;
	} cfg_t;

	typedef struct packed {
		logic       hit;
		logic       mono;
		logic [7:0] dx;
		logic [8:0] dy;
	} win_t;

	typedef struct packed {
		logic       hit;
		logic       mono;
		logic       oob_a;
		logic       oob_b;
		logic [1:0] lane_a;
		logic [1:0] lane_b;
		logic [2:0] bit_idx;
	} sel_t;

	typedef struct packed {
		logic [SHAPE_AW-1:0] word_a;
		logic [SHAPE_AW-1:0] word_b;
		sel_t                sel;
	} addr_t;

endpackage

`default_nettype wire

// ===== rtl/cmo_window.sv =====
// ----------------------------------------------------------------------------
// cmo_window
// cursor rectangle test and offsets of a pixel inside it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmo_window (
	input  wire logic [12:0]  pixel_x,
	input  wire logic [12:0]  pixel_y,
	input  wire cmo_pkg::cfg_t cfg,
	output cmo_pkg::win_t     win
);

	logic [12:0] xc;
	logic [12:0] yc;
	logic [14:0] sx;
	logic [14:0] sy;
	logic [8:0]  vis_h;
	logic        mono;
	logic        color;

	always_comb begin
		xc    = pixel_x & cmo_pkg::COORD_MASK;
		yc    = pixel_y & cmo_pkg::COORD_MASK;
		sx    = {2'b00, xc} - {cfg.cursor_x[13], cfg.cursor_x};
		sy    = {2'b00, yc} - {cfg.cursor_y[13], cfg.cursor_y};
		mono  = (cfg.cursor_mode == cmo_pkg::MODE_MONO);
		color = (cfg.cursor_mode == cmo_pkg::MODE_COLOR);
		vis_h = mono ? {1'b0, cfg.shape_height[8:1]} : cfg.shape_height;

		win.hit    = (mono || color) && !sx[14] && !sy[14] &&
			(sx[13:0] < {6'b0, cfg.shape_width}) &&
			(sy[13:0] < {5'b0, vis_h});
		win.mono   = mono;
		win.dx     = sx[7:0];
		win.dy     = sy[8:0];
	end

endmodule

`default_nettype wire

// ===== rtl/cmo_addr.sv =====
// ----------------------------------------------------------------------------
// cmo_addr
// shape store addresses for the and/xor planes or the colour word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmo_addr (
	input  wire cmo_pkg::win_t  win,
	input  wire logic [8:0]     shape_height,
	input  wire logic [9:0]     shape_pitch,
	output cmo_pkg::addr_t      addr
);

	logic [9:0]                  mul_in;
	logic [9:0]                  dy_xor;
	logic [7:0]                  base_a;
	logic [cmo_pkg::BADDR_W-1:0] sum_a;
	logic [cmo_pkg::BADDR_W-1:0] sum_b;
	logic [cmo_pkg::BADDR_W-1:0] wa;
	logic [cmo_pkg::BADDR_W-1:0] wb;

	always_comb begin
		mul_in = win.mono ? shape_pitch : {2'b00, shape_pitch[9:2]};
		base_a = win.mono ? {3'b000, win.dx[7:3]} : win.dx;
		dy_xor = {1'b0, win.dy} + {2'b00, shape_height[8:1]};

		sum_a = cmo_pkg::BADDR_W'(mul_in) * cmo_pkg::BADDR_W'(win.dy)
			+ cmo_pkg::BADDR_W'(base_a);
		sum_b = cmo_pkg::BADDR_W'(shape_pitch) * cmo_pkg::BADDR_W'(dy_xor)
			+ cmo_pkg::BADDR_W'(win.dx[7:3]);

		wa = win.mono ? (sum_a >> 2) : sum_a;
		wb = sum_b >> 2;

		addr.word_a       = wa[cmo_pkg::SHAPE_AW-1:0];
		addr.word_b       = wb[cmo_pkg::SHAPE_AW-1:0];
		addr.sel.hit      = win.hit;
		addr.sel.mono     = win.mono;
		addr.sel.oob_a    = (wa >= cmo_pkg::BADDR_W'(cmo_pkg::SHAPE_WORDS));
		addr.sel.oob_b    = (wb >= cmo_pkg::BADDR_W'(cmo_pkg::SHAPE_WORDS));
		addr.sel.lane_a   = sum_a[1:0];
		addr.sel.lane_b   = sum_b[1:0];
		addr.sel.bit_idx  = win.dx[2:0];
	end

endmodule

`default_nettype wire

// ===== rtl/cmo_shape_ram.sv =====
// ----------------------------------------------------------------------------
// cmo_shape_ram
// shape store, one write port and two registered read ports
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmo_shape_ram (
	input  wire logic                         clk,
	input  wire logic                         we,
	input  wire logic [cmo_pkg::SHAPE_AW-1:0] waddr,
	input  wire logic [31:0]                  wdata,
	input  wire logic                         re,
	input  wire logic [cmo_pkg::SHAPE_AW-1:0] raddr_a,
	input  wire logic [cmo_pkg::SHAPE_AW-1:0] raddr_b,
	output logic      [31:0]                  rdata_a,
	output logic      [31:0]                  rdata_b
);

	logic [31:0] mem [cmo_pkg::SHAPE_WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/cmo_compose.sv =====
// ----------------------------------------------------------------------------
// cmo_compose
// and/xor mask or masked colour merge of one desktop pixel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmo_compose (
	input  wire cmo_pkg::sel_t sel,
	input  wire logic [31:0]   pixel,
	input  wire logic [31:0]   rdata_a,
	input  wire logic [31:0]   rdata_b,
	output logic      [31:0]   pixel_out
);

	logic [7:0]  byte_a;
	logic [7:0]  byte_b;
	logic        and_bit;
	logic        xor_bit;
	logic [31:0] and32;
	logic [31:0] xor32;
	logic [31:0] shape;

	always_comb begin
		byte_a  = 8'(rdata_a >> {sel.lane_a, 3'b000});
		byte_b  = 8'(rdata_b >> {sel.lane_b, 3'b000});
		and_bit = !sel.oob_a && byte_a[cmo_pkg::MSB_BIT - sel.bit_idx];
		xor_bit = !sel.oob_b && byte_b[cmo_pkg::MSB_BIT - sel.bit_idx];
		and32   = and_bit ? cmo_pkg::ALL_ONES : cmo_pkg::ALPHA_MASK;
		xor32   = xor_bit ? cmo_pkg::RGB_MASK : cmo_pkg::ZERO_WORD;
		shape   = sel.oob_a ? cmo_pkg::ZERO_WORD : rdata_a;

		if (!sel.hit) begin
			pixel_out = pixel;
		end else if (sel.mono) begin
			pixel_out = (pixel & and32) ^ xor32;
		end else if ((shape & cmo_pkg::ALPHA_MASK) != cmo_pkg::ZERO_WORD) begin
			pixel_out = (pixel ^ shape) | cmo_pkg::ALPHA_MASK;
		end else begin
			pixel_out = shape;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/cursor_mask_overlay.sv =====
// ----------------------------------------------------------------------------
// cursor_mask_overlay
// hardware cursor compositor with and/xor mask and masked colour shapes
// a pixel result passes the window register, the shape store read and the output
// register in turn; shape writes give no result
// throughput: one item per cycle while the output is not stalled, set by the single pass through the store
// reset clears control and config; the shape store is not cleared
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "cursor_mask_overlay_defines.svh"

module cursor_mask_overlay (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [2:0]       cfg_index,
	input  wire logic [13:0]      cfg_data,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire cmo_pkg::item_t   item,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output cmo_pkg::result_t      result
);

	cmo_pkg::cfg_t  cfg_q;
	cmo_pkg::win_t  win;
	cmo_pkg::addr_t addr;

	logic            valid_s1;
	cmo_pkg::item_t  item_s1;
	cmo_pkg::win_t   win_s1;
	logic            valid_s2;
	logic [31:0]     pix_s2;
	cmo_pkg::sel_t   sel_s2;
	logic            valid_s3;
	cmo_pkg::result_t res_s3;

	logic        en1;
	logic        en2;
	logic        en3;
	logic        is_pixel_s1;
	logic        mem_we;
	logic        mem_re;
	logic [cmo_pkg::BADDR_W-1:0] waddr_ext;
	logic [31:0] rdata_a;
	logic [31:0] rdata_b;
	logic [31:0] composed;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cursor_x     <= '0;
			cfg_q.cursor_y     <= '0;
			cfg_q.cursor_mode  <= cmo_pkg::MODE_OFF;
			cfg_q.shape_width  <= cmo_pkg::RST_WIDTH;
			cfg_q.shape_height <= cmo_pkg::RST_HEIGHT;
			cfg_q.shape_pitch  <= cmo_pkg::RST_PITCH;
		end else if (cfg_we) begin
			case (cmo_pkg::cfg_reg_t'(cfg_index))
				cmo_pkg::REG_CURSOR_X:     cfg_q.cursor_x     <= cfg_data;
				cmo_pkg::REG_CURSOR_Y:     cfg_q.cursor_y     <= cfg_data;
				cmo_pkg::REG_CURSOR_MODE:  cfg_q.cursor_mode  <= cfg_data[1:0];
				cmo_pkg::REG_SHAPE_WIDTH:  cfg_q.shape_width  <= cfg_data[7:0];
				cmo_pkg::REG_SHAPE_HEIGHT: cfg_q.shape_height <= cfg_data[8:0];
				cmo_pkg::REG_SHAPE_PITCH:  cfg_q.shape_pitch  <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// stage enables, bubbles collapse
	always_comb begin
		en3         = !valid_s3 || !result_stall;
		en2         = !valid_s2 || en3;
		en1         = !valid_s1 || en2;
		item_stall  = !en1;
		is_pixel_s1 = (item_s1.opcode == cmo_pkg::OP_PIXEL);
		waddr_ext   = cmo_pkg::BADDR_W'(item_s1.shape_word_addr);
		mem_we      = en2 && valid_s1 && !is_pixel_s1 &&
			(waddr_ext < cmo_pkg::BADDR_W'(cmo_pkg::SHAPE_WORDS));
		mem_re      = en2 && valid_s1 && is_pixel_s1;
	end

	cmo_window u_window (
		.pixel_x (item.pixel_x),
		.pixel_y (item.pixel_y),
		.cfg     (cfg_q),
		.win     (win)
	);

	cmo_addr u_addr (
		.win          (win_s1),
		.shape_height (cfg_q.shape_height),
		.shape_pitch  (cfg_q.shape_pitch),
		.addr         (addr)
	);

	cmo_shape_ram u_ram (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (waddr_ext[cmo_pkg::SHAPE_AW-1:0]),
		.wdata   (item_s1.shape_word),
		.re      (mem_re),
		.raddr_a (addr.word_a),
		.raddr_b (addr.word_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	cmo_compose u_compose (
		.sel       (sel_s2),
		.pixel     (pix_s2),
		.rdata_a   (rdata_a),
		.rdata_b   (rdata_b),
		.pixel_out (composed)
	);

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= item_valid;
			end
			if (en2) begin
				valid_s2 <= valid_s1 && is_pixel_s1;
			end
			if (en3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (en1) begin
			item_s1 <= item;
			win_s1  <= win;
		end
		if (en2) begin
			pix_s2 <= item_s1.desktop_pixel;
			sel_s2 <= addr.sel;
		end
		if (en3) begin
			res_s3.pixel_out <= composed;
			res_s3.in_cursor <= sel_s2.hit;
		end
	end

	assign result_valid = valid_s3;
	assign result       = res_s3;

	`CMO_ASSERT_NOW(a_empty_no_stall, !valid_s1, !item_stall, "stall with empty first stage")
	`CMO_ASSERT_NOW(a_full_stall, valid_s1 && !en2, item_stall, "transfer into full pipeline")
	`CMO_ASSERT_NEXT(a_outside_pass, en3 && valid_s2 && !sel_s2.hit, result.pixel_out == $past(pix_s2), "pixel outside cursor altered")

endmodule

`default_nettype wire

// ===== test/cursor_mask_overlay_tb.sv =====
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// cursor_mask_overlay_tb
// self-checking bench for the cursor overlay: shape writes and desktop pixels
// go in with random gaps while the output side stalls at random; a mirror of
// the shape store and cursor registers predicts every composited pixel, and
// results are checked in order, field by field
// ----------------------------------------------------------------------------
module cursor_mask_overlay_tb;
	import cmo_pkg::*;

	localparam int         IDLE_LIMIT    = 4000;
	localparam int         SETTLE_CYCLES = 8;
	localparam int         PHASE_ITEMS   = 88;
	localparam int         COORD_MAX     = (1 << COORD_BITS) - 1;
	localparam logic [1:0] MODE_SPARE    = 2'd3;
	localparam logic [2:0] REG_SPARE_LO  = 3'd6;
	localparam logic [2:0] REG_SPARE_HI  = 3'd7;

	logic        clk;
	logic        arst_n       = 1'b0;
	logic        cfg_we       = 1'b0;
	logic [2:0]  cfg_index    = '0;
	logic [13:0] cfg_data     = '0;
	logic        item_valid   = 1'b0;
	logic        item_stall;
	item_t       item         = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	result_t     result;

	cursor_mask_overlay u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// mirror of the cursor registers and shape store
	logic signed [13:0] cur_x     = '0;
	logic signed [13:0] cur_y     = '0;
	logic [1:0]         cur_mode  = MODE_OFF;
	logic [7:0]         shp_w     = RST_WIDTH;
	logic [8:0]         shp_h     = RST_HEIGHT;
	logic [9:0]         shp_pitch = RST_PITCH;
	logic [31:0]        shape_mem [SHAPE_WORDS];
	bit                 shape_written [SHAPE_WORDS];

	result_t pixels_due [$];

	int errors         = 0;
	int pixels_checked = 0;
	int writes_sent    = 0;
	int settings_run   = 0;
	int idle_cycles    = 0;
	int hold_req       = 0;
	int rx_wait        = 0;
	bit tx_steady      = 1'b0;
	bit rx_steady      = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap(bit steady);
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [31:0] rand_shape_word();
		logic [31:0] w;
		w = $urandom;
		if ($urandom_range(0, 2) == 0)
			w[31:24] = 8'h00;
		return w;
	endfunction

	// ------------------------------------------------------------------ model

	function automatic bit cursor_hit(input item_t it, output int dx, output int dy);
		int vis_h;
		dx = int'(it.pixel_x) - int'(cur_x);
		dy = int'(it.pixel_y) - int'(cur_y);
		vis_h = (cur_mode == MODE_MONO) ? int'(shp_h >> 1) : int'(shp_h);
		return (cur_mode == MODE_MONO || cur_mode == MODE_COLOR) &&
			dx >= 0 && dy >= 0 && dx < int'(shp_w) && dy < vis_h;
	endfunction

	function automatic int mono_byte(int dx, int row);
		return dx / 8 + int'(shp_pitch) * row;
	endfunction

	function automatic int color_word(int dx, int dy);
		return dx + int'(shp_pitch >> 2) * dy;
	endfunction

	function automatic logic [31:0] shape_word_at(int w);
		if (w >= SHAPE_WORDS)
			return ZERO_WORD;
		return shape_mem[w];
	endfunction

	function automatic logic [7:0] shape_byte_at(int b);
		return 8'(shape_word_at(b / 4) >> (8 * (b % 4)));
	endfunction

	// store words a pixel reads, -1 where none
	function automatic void words_read(input item_t it, output int wa, output int wb);
		int dx, dy;
		wa = -1;
		wb = -1;
		if (it.opcode == OP_PIXEL && cursor_hit(it, dx, dy)) begin
			if (cur_mode == MODE_MONO) begin
				wa = mono_byte(dx, dy) / 4;
				wb = mono_byte(dx, dy + int'(shp_h >> 1)) / 4;
			end else begin
				wa = color_word(dx, dy);
			end
		end
	endfunction

	function automatic result_t composite_pixel(item_t it);
		result_t     r;
		int          dx, dy;
		logic [7:0]  bit_sel, and_bits, xor_bits;
		logic [31:0] s;
		r.pixel_out = it.desktop_pixel;
		r.in_cursor = 1'b0;
		if (cursor_hit(it, dx, dy)) begin
			r.in_cursor = 1'b1;
			if (cur_mode == MODE_MONO) begin
				bit_sel  = 8'h80 >> (dx % 8);
				and_bits = shape_byte_at(mono_byte(dx, dy)) & bit_sel;
				xor_bits = shape_byte_at(mono_byte(dx, dy + int'(shp_h >> 1))) & bit_sel;
				r.pixel_out = (it.desktop_pixel & ((and_bits != 0) ? ALL_ONES : ALPHA_MASK)) ^
					((xor_bits != 0) ? RGB_MASK : ZERO_WORD);
			end else begin
				s = shape_word_at(color_word(dx, dy));
				r.pixel_out = ((s & ALPHA_MASK) != 0) ? ((it.desktop_pixel ^ s) | ALPHA_MASK) : s;
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------ driving

	task automatic send_item(item_t it);
		int gap;
		gap = pick_gap(tx_steady);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		if (it.opcode == OP_WRITE) begin
			shape_mem[it.shape_word_addr]     = it.shape_word;
			shape_written[it.shape_word_addr] = 1'b1;
			writes_sent++;
		end else begin
			pixels_due = {pixels_due, composite_pixel(it)};
		end
	endtask

	task automatic send_write(int addr, logic [31:0] word);
		item_t it;
		it.opcode          = OP_WRITE;
		it.shape_word_addr = 14'(addr);
		it.shape_word      = word;
		it.pixel_x         = 13'($urandom);
		it.pixel_y         = 13'($urandom);
		it.desktop_pixel   = $urandom;
		send_item(it);
	endtask

	// shape words the pixel reads are loaded first if they were never written
	task automatic send_pixel(int x, int y, logic [31:0] px);
		item_t it;
		int    wa, wb;
		it.opcode          = OP_PIXEL;
		it.shape_word_addr = 14'($urandom);
		it.shape_word      = $urandom;
		it.pixel_x         = 13'(x);
		it.pixel_y         = 13'(y);
		it.desktop_pixel   = px;
		words_read(it, wa, wb);
		if (wa >= 0 && wa < SHAPE_WORDS && !shape_written[wa])
			send_write(wa, rand_shape_word());
		if (wb >= 0 && wb < SHAPE_WORDS && !shape_written[wb])
			send_write(wb, rand_shape_word());
		send_item(it);
	endtask

	task automatic settle(int extra);
		item_valid <= 1'b0;
		while (pixels_due.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic put_reg(logic [2:0] idx, logic [13:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic apply_cursor(int x, int y, logic [1:0] mode, int w, int h, int p);
		settle(SETTLE_CYCLES);
		put_reg(REG_CURSOR_X, 14'(x));
		put_reg(REG_CURSOR_Y, 14'(y));
		put_reg(REG_CURSOR_MODE, 14'(mode));
		put_reg(REG_SHAPE_WIDTH, 14'(w));
		put_reg(REG_SHAPE_HEIGHT, 14'(h));
		put_reg(REG_SHAPE_PITCH, 14'(p));
		put_reg(REG_SPARE_LO, 14'($urandom));
		put_reg(REG_SPARE_HI, 14'($urandom));
		cfg_we    <= 1'b0;
		cur_x     = 14'(x);
		cur_y     = 14'(y);
		cur_mode  = mode;
		shp_w     = 8'(w);
		shp_h     = 9'(h);
		shp_pitch = 10'(p);
		settings_run++;
	endtask

	function automatic int near_coord(int base, int span);
		int lo, hi;
		lo = (base - 1 < 0) ? 0 : base - 1;
		hi = (base + span > COORD_MAX) ? COORD_MAX : base + span;
		if (lo > hi)
			return $urandom_range(0, COORD_MAX);
		return $urandom_range(lo, hi);
	endfunction

	task automatic random_item();
		int r;
		r = $urandom_range(0, 99);
		if (r < 9)
			send_write($urandom_range(0, 1023), rand_shape_word());
		else if (r < 18)
			send_write($urandom_range(0, SHAPE_WORDS - 1), rand_shape_word());
		else if (r < 88)
			send_pixel(near_coord(int'(cur_x), int'(shp_w)), near_coord(int'(cur_y), int'(shp_h)),
				$urandom);
		else
			send_pixel($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX), $urandom);
	endtask

	task automatic run_items(int count);
		for (int i = 0; i < count; i++) begin
			if (i % 25 == 0) begin
				tx_steady = ($urandom_range(0, 3) == 0);
				rx_steady = ($urandom_range(0, 3) == 0);
			end
			random_item();
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// ------------------------------------------------------------------ tests

	task automatic test_reset_state();
		send_pixel(0, 0, ZERO_WORD);
		send_pixel(COORD_MAX, COORD_MAX, ALL_ONES);
		send_pixel(5, 5, $urandom);
	endtask

	// odd height, negative left edge; one word gives all four and/xor pairs
	task automatic test_mono_planes();
		apply_cursor(-3, COORD_MAX - 1, MODE_MONO, 8, 5, 1);
		send_write(0, 32'h1001_1100);
		send_pixel(0, COORD_MAX - 1, $urandom);
		send_pixel(4, COORD_MAX - 1, $urandom);
		send_pixel(0, COORD_MAX, $urandom);
		send_pixel(4, COORD_MAX, ALL_ONES);
		send_pixel(5, COORD_MAX - 1, $urandom);
		send_pixel(0, COORD_MAX - 2, $urandom);
	endtask

	// pitch not a multiple of four, alpha zero and nonzero shape words
	task automatic test_color_words();
		apply_cursor(COORD_MAX - 1, 0, MODE_COLOR, 2, 2, 6);
		send_write(0, 32'h0012_3456);
		send_write(1, 32'h80FF_FFFF);
		send_write(2, ALPHA_MASK);
		send_pixel(COORD_MAX - 1, 0, $urandom);
		send_pixel(COORD_MAX, 0, ZERO_WORD);
		send_pixel(COORD_MAX - 1, 1, ALL_ONES);
		send_pixel(COORD_MAX, 1, $urandom);
		send_pixel(COORD_MAX - 2, 0, $urandom);
	endtask

	task automatic test_odd_cases();
		apply_cursor(0, 0, MODE_SPARE, 32, 64, 4);
		send_pixel(1, 1, $urandom);
		apply_cursor(0, 0, MODE_COLOR, 0, 8, 4);
		send_pixel(0, 0, $urandom);
		apply_cursor(0, 0, MODE_COLOR, 8, 0, 4);
		send_pixel(0, 0, $urandom);
		apply_cursor(0, 0, MODE_MONO, 8, 1, 1);
		send_pixel(0, 0, $urandom);
	endtask

	task automatic test_backpressure();
		apply_cursor(40, 24, MODE_MONO, 16, 16, 2);
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		hold_req  = 200;
		repeat (48) send_pixel(near_coord(40, 16), near_coord(24, 8), $urandom);
		settle(1);
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		repeat (40) random_item();
	endtask

	task automatic test_random_settings();
		int         x, y;
		logic [1:0] mode;
		apply_cursor(-128, -128, MODE_MONO, 128, 256, 512);
		run_items(PHASE_ITEMS);
		apply_cursor(COORD_MAX, COORD_MAX, MODE_COLOR, 1, 1, 4);
		run_items(PHASE_ITEMS);
		apply_cursor(-128, COORD_MAX, MODE_COLOR, 128, 256, 512);
		run_items(PHASE_ITEMS);
		apply_cursor(COORD_MAX, -128, MODE_MONO, 1, 2, 1);
		run_items(PHASE_ITEMS);
		apply_cursor(100, 200, MODE_MONO, 255, 511, 1023);
		run_items(PHASE_ITEMS);
		apply_cursor(0, 0, MODE_COLOR, 255, 511, 1023);
		run_items(PHASE_ITEMS);
		for (int i = 0; i < 8; i++) begin
			x = int'($urandom_range(0, COORD_MAX + 128)) - 128;
			y = int'($urandom_range(0, COORD_MAX + 128)) - 128;
			if ($urandom_range(0, 5) == 0)
				mode = 2'($urandom_range(0, 3));
			else
				mode = $urandom_range(0, 1) ? MODE_MONO : MODE_COLOR;
			apply_cursor(x, y, mode, $urandom_range(1, 48), $urandom_range(1, 64),
				$urandom_range(1, 24));
			run_items(PHASE_ITEMS);
		end
	endtask

	// ------------------------------------------------------------------ output side

	always @(posedge clk) begin
		int n;
		if (hold_req > 0) begin
			result_stall <= 1'b1;
			rx_wait      <= hold_req - 1;
			hold_req     = 0;
		end else if (rx_wait > 0) begin
			result_stall <= 1'b1;
			rx_wait      <= rx_wait - 1;
		end else begin
			n = pick_gap(rx_steady);
			result_stall <= (n > 0);
			rx_wait      <= (n > 0) ? n - 1 : 0;
		end
	end

	task automatic report_mismatch(string what);
		if (errors < 100)
			$display("mismatch at %0t: %s", $time, what);
		errors++;
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pixels_due.size() == 0) begin
				report_mismatch($sformatf("result %h with no pixel pending", result));
			end else begin
				want = pixels_due.pop_front();
				pixels_checked++;
				if (result.pixel_out !== want.pixel_out)
					report_mismatch($sformatf("pixel_out %h, predicted %h",
						result.pixel_out, want.pixel_out));
				if (result.in_cursor !== want.in_cursor)
					report_mismatch($sformatf("in_cursor %b, predicted %b",
						result.in_cursor, want.in_cursor));
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_mono_planes();
		test_color_words();
		test_odd_cases();
		test_backpressure();
		test_random_settings();
		settle(SETTLE_CYCLES);
		$display("summary: %0d pixels checked, %0d shape writes, %0d cursor settings",
			pixels_checked, writes_sent, settings_run);
		$display("summary: mono and color shapes, off and spare modes, empty and oversized %s",
			"cursors, long output hold-off");
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
